### rtl/owers_pkg.sv
// ----------------------------------------------------------------------------
// owers_pkg
// Shared types and constants of the one-way elevator request scheduler:
// operation and status codes, item structs and the scan unit control group.
// ----------------------------------------------------------------------------
package owers_pkg;

    // default sizes of the request table
    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_SECTOR_BITS = 48;

    // fixed field widths of the items
    localparam int IN_SECTOR_BITS  = 48;
    localparam int OUT_SECTOR_BITS = 48;
    localparam int COUNT_BITS      = 16;
    localparam int TAG_BITS        = 8;

    // operation codes
    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_MERGE    = 2'd2,
        OP_REMOVE   = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [2:0] {
        ST_STORED     = 3'd0,
        ST_DISPATCHED = 3'd1,
        ST_MERGED     = 3'd2,
        ST_NO_MERGE   = 3'd3,
        ST_FULL       = 3'd4,
        ST_EMPTY      = 3'd5,
        ST_NOT_FOUND  = 3'd6
    } t_status;

    // input item
    typedef struct packed {
        logic [1:0]                operation;
        logic [IN_SECTOR_BITS-1:0] start_sector;
        logic [COUNT_BITS-1:0]     sector_count;
        logic [TAG_BITS-1:0]       request_tag;
        logic                      merge_allowed;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [2:0]                 status;
        logic [TAG_BITS-1:0]        out_tag;
        logic [OUT_SECTOR_BITS-1:0] out_sector;
        logic [COUNT_BITS-1:0]      out_count;
        logic                       queue_empty;
    } t_out_item;

    // what the scan unit compares an entry against
    typedef enum logic [1:0] {
        SM_SECTOR = 2'd0,
        SM_TAG    = 2'd1,
        SM_INDEX  = 2'd2
    } t_scan_mode;

    // sequencer to scan unit
    typedef struct packed {
        logic       start;
        t_scan_mode mode;
        logic       bounded;
        logic       skip_en;
    } t_scan_ctl;

    // scan unit to sequencer
    typedef struct packed {
        logic done;
        logic match_found;
        logic best_found;
        logic free_found;
    } t_scan_flags;

endpackage

### rtl/owers_ram.sv
// ----------------------------------------------------------------------------
// owers_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module owers_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/owers_scan.sv
// ----------------------------------------------------------------------------
// owers_scan
// Shared scan unit: walks the entry memory one slot a cycle and keeps the
// first matching entry, the smallest sector (optionally above a key) and the
// first free slot.
// ----------------------------------------------------------------------------
module owers_scan #(
    parameter  int TABLE_DEPTH = owers_pkg::DEF_TABLE_DEPTH,
    parameter  int SECTOR_BITS = owers_pkg::DEF_SECTOR_BITS,
    localparam int IW          = $clog2(TABLE_DEPTH),
    localparam int TB          = owers_pkg::TAG_BITS,
    localparam int WW          = SECTOR_BITS + owers_pkg::COUNT_BITS + TB
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  owers_pkg::t_scan_ctl   i_ctl,
    input  logic [SECTOR_BITS-1:0] i_key_sec,
    input  logic [TB-1:0]          i_key_tag,
    input  logic [IW-1:0]          i_key_idx,
    output logic                   o_rd_en,
    output logic [IW-1:0]          o_rd_addr,
    input  logic [WW-1:0]          i_rd_data,
    output logic [IW-1:0]          o_cmp_idx,
    input  logic                   i_cmp_valid,
    output owers_pkg::t_scan_flags o_flags,
    output logic [IW-1:0]          o_match_idx,
    output logic [WW-1:0]          o_match_word,
    output logic [IW-1:0]          o_best_idx,
    output logic [WW-1:0]          o_best_word,
    output logic [IW-1:0]          o_free_idx
);

    logic                   r_busy;
    logic [IW:0]            r_cnt;
    logic                   r_dv;
    logic [IW-1:0]          r_didx;
    logic                   r_done;
    logic                   r_match_found;
    logic                   r_best_found;
    logic                   r_free_found;
    logic [IW-1:0]          r_match_idx;
    logic [WW-1:0]          r_match_word;
    logic [IW-1:0]          r_best_idx;
    logic [WW-1:0]          r_best_word;
    logic [IW-1:0]          r_free_idx;

    logic [SECTOR_BITS-1:0] w_sec;
    logic [TB-1:0]          w_tag;
    logic                   w_cand;
    logic                   w_eq;
    logic                   w_above;
    logic                   w_take_match;
    logic                   w_take_best;
    logic                   w_take_free;

    // entry fields of the slot under compare
    assign w_sec = i_rd_data[SECTOR_BITS-1:0];
    assign w_tag = i_rd_data[WW-1 -: TB];

    // compare of one entry against the key and the trackers
    always_comb begin
        w_cand = i_cmp_valid && !(i_ctl.skip_en && (r_didx == i_key_idx));
        case (i_ctl.mode)
            owers_pkg::SM_SECTOR: w_eq = (w_sec == i_key_sec);
            owers_pkg::SM_TAG:    w_eq = (w_tag == i_key_tag);
            owers_pkg::SM_INDEX:  w_eq = (r_didx == i_key_idx);
            default:              w_eq = 1'b0;
        endcase
        w_above      = !i_ctl.bounded || (w_sec > i_key_sec);
        w_take_match = r_dv && w_cand && w_eq && !r_match_found;
        w_take_best  = r_dv && w_cand && w_above &&
                       (!r_best_found || (w_sec < r_best_word[SECTOR_BITS-1:0]));
        w_take_free  = r_dv && !i_cmp_valid && !r_free_found;
    end

    // address counter, read pipeline and found flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_cnt         <= '0;
            r_dv          <= 1'b0;
            r_done        <= 1'b0;
            r_match_found <= 1'b0;
            r_best_found  <= 1'b0;
            r_free_found  <= 1'b0;
        end else begin
            r_done <= r_dv && (r_didx == IW'(TABLE_DEPTH - 1));
            r_dv   <= r_busy;
            if (r_busy) begin
                r_cnt <= r_cnt + (IW+1)'(1);
                if (r_cnt == (IW+1)'(TABLE_DEPTH - 1)) begin
                    r_busy <= 1'b0;
                end
            end
            if (i_ctl.start) begin
                r_busy        <= 1'b1;
                r_cnt         <= '0;
                r_match_found <= 1'b0;
                r_best_found  <= 1'b0;
                r_free_found  <= 1'b0;
            end else begin
                if (w_take_match) begin
                    r_match_found <= 1'b1;
                end
                if (w_take_best) begin
                    r_best_found <= 1'b1;
                end
                if (w_take_free) begin
                    r_free_found <= 1'b1;
                end
            end
        end
    end

    // captured slot indexes and entry words
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_didx <= r_cnt[IW-1:0];
        end
        if (w_take_match) begin
            r_match_idx  <= r_didx;
            r_match_word <= i_rd_data;
        end
        if (w_take_best) begin
            r_best_idx  <= r_didx;
            r_best_word <= i_rd_data;
        end
        if (w_take_free) begin
            r_free_idx <= r_didx;
        end
    end

    assign o_rd_en             = r_busy;
    assign o_rd_addr           = r_cnt[IW-1:0];
    assign o_cmp_idx           = r_didx;
    assign o_flags.done        = r_done;
    assign o_flags.match_found = r_match_found;
    assign o_flags.best_found  = r_best_found;
    assign o_flags.free_found  = r_free_found;
    assign o_match_idx         = r_match_idx;
    assign o_match_word        = r_match_word;
    assign o_best_idx          = r_best_idx;
    assign o_best_word         = r_best_word;
    assign o_free_idx          = r_free_idx;

endmodule

### rtl/one_way_elevator_request_scheduler.sv
// ----------------------------------------------------------------------------
// one_way_elevator_request_scheduler
// One-way (C-LOOK) disk request scheduler over a table of pending requests.
// ----------------------------------------------------------------------------
// The block handles one item at a time and holds its input stall high until
// the result is registered. An add takes one pass over the request table. A
// dispatch, a merge that succeeds and a remove that has to move the next
// pointer take two passes; other items end after the first pass, and a
// dispatch on an empty table needs no pass at all. The scan unit reads one
// entry per cycle through the single read port of the entry memory; a result
// that finds the output register still stalled waits until it is free.
// Valid bits sit in flip-flops, so the block is ready right after reset with
// no clearing pass. A finished result waits in the output register while the
// next item is taken.
// ----------------------------------------------------------------------------
module one_way_elevator_request_scheduler #(
    parameter int TABLE_DEPTH = owers_pkg::DEF_TABLE_DEPTH,
    parameter int SECTOR_BITS = owers_pkg::DEF_SECTOR_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  owers_pkg::t_in_item  i_in,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output owers_pkg::t_out_item o_out,
    input  logic                 i_out_stall
);

    localparam int IW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int SB  = SECTOR_BITS;
    localparam int NB  = owers_pkg::COUNT_BITS;
    localparam int TB  = owers_pkg::TAG_BITS;
    localparam int OSB = owers_pkg::OUT_SECTOR_BITS;
    localparam int WW  = SB + NB + TB;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN1 = 4'b0010,
        S_SCAN2 = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    owers_pkg::t_op         r_op, n_op;
    logic [SB-1:0]          r_sec, n_sec;
    logic [NB-1:0]          r_cnt, n_cnt;
    logic [TB-1:0]          r_tag, n_tag;
    logic                   r_allow, n_allow;
    logic                   r_start, n_start;
    owers_pkg::t_scan_mode  r_mode, n_mode;
    logic                   r_bounded, n_bounded;
    logic                   r_skip_en, n_skip_en;
    logic [SB-1:0]          r_key_sec, n_key_sec;
    logic [IW-1:0]          r_key_idx, n_key_idx;
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic [CW-1:0]          r_nvalid, n_nvalid;
    logic [IW-1:0]          r_next_idx, n_next_idx;
    logic                   r_next_vld, n_next_vld;
    logic                   r_we, n_we;
    logic [IW-1:0]          r_waddr, n_waddr;
    logic [WW-1:0]          r_wdata, n_wdata;
    owers_pkg::t_out_item   r_res, n_res;
    owers_pkg::t_out_item   r_out, n_out;
    logic                   r_out_vld, n_out_vld;

    owers_pkg::t_scan_ctl   w_ctl;
    owers_pkg::t_scan_flags w_flags;
    logic                   w_rd_en;
    logic [IW-1:0]          w_rd_addr;
    logic [WW-1:0]          w_rd_data;
    logic [IW-1:0]          w_cmp_idx;
    logic                   w_cmp_valid;
    logic [IW-1:0]          w_match_idx;
    logic [WW-1:0]          w_match_word;
    logic [IW-1:0]          w_best_idx;
    logic [WW-1:0]          w_best_word;
    logic [IW-1:0]          w_free_idx;
    logic [SB-1:0]          w_in_sec;
    logic [SB-1:0]          w_end;
    logic [NB:0]            w_sum;
    logic [IW-1:0]          w_slot;
    logic [IW-1:0]          w_sel_idx;
    logic [WW-1:0]          w_sel_word;
    logic [WW-1:0]          w_merged;

    // result fields from an entry word
    function automatic owers_pkg::t_out_item f_report(owers_pkg::t_status st,
                                                      logic [WW-1:0] w);
        owers_pkg::t_out_item res;
        res             = '0;
        res.status      = st;
        res.out_tag     = w[WW-1 -: TB];
        res.out_count   = w[SB+NB-1:SB];
        res.out_sector  = OSB'(w[SB-1:0]);
        res.queue_empty = 1'b0;
        return res;
    endfunction

    // entry memory
    owers_ram #(
        .WIDTH (WW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_we),
        .i_waddr (r_waddr),
        .i_wdata (r_wdata),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    // shared scan unit
    assign w_ctl.start   = r_start;
    assign w_ctl.mode    = r_mode;
    assign w_ctl.bounded = r_bounded;
    assign w_ctl.skip_en = r_skip_en;
    assign w_cmp_valid   = r_valid[w_cmp_idx];

    owers_scan #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SECTOR_BITS (SECTOR_BITS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_key_sec    (r_key_sec),
        .i_key_tag    (r_tag),
        .i_key_idx    (r_key_idx),
        .o_rd_en      (w_rd_en),
        .o_rd_addr    (w_rd_addr),
        .i_rd_data    (w_rd_data),
        .o_cmp_idx    (w_cmp_idx),
        .i_cmp_valid  (w_cmp_valid),
        .o_flags      (w_flags),
        .o_match_idx  (w_match_idx),
        .o_match_word (w_match_word),
        .o_best_idx   (w_best_idx),
        .o_best_word  (w_best_word),
        .o_free_idx   (w_free_idx)
    );

    // input sector, merge end sector and grown merge count
    assign w_in_sec = SB'(i_in.start_sector);
    assign w_end    = w_in_sec + SB'(i_in.sector_count);
    assign w_sum    = {1'b0, w_match_word[SB+NB-1:SB]} + {1'b0, r_cnt};
    assign w_merged = {w_match_word[WW-1 -: TB], w_sum[NB-1:0], r_sec};

    // slot reused by an add: lowest free slot, counting the dispatched one
    assign w_slot = (w_flags.free_found && (w_free_idx < w_match_idx)) ?
                    w_free_idx : w_match_idx;

    // dispatch picks the pointed-to entry if still valid, else the lowest
    assign w_sel_idx  = (r_next_vld && w_flags.match_found) ? w_match_idx : w_best_idx;
    assign w_sel_word = (r_next_vld && w_flags.match_found) ? w_match_word : w_best_word;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_sec      = r_sec;
        n_cnt      = r_cnt;
        n_tag      = r_tag;
        n_allow    = r_allow;
        n_start    = 1'b0;
        n_mode     = r_mode;
        n_bounded  = r_bounded;
        n_skip_en  = r_skip_en;
        n_key_sec  = r_key_sec;
        n_key_idx  = r_key_idx;
        n_valid    = r_valid;
        n_nvalid   = r_nvalid;
        n_next_idx = r_next_idx;
        n_next_vld = r_next_vld;
        n_we       = 1'b0;
        n_waddr    = r_waddr;
        n_wdata    = r_wdata;
        n_res      = r_res;
        n_out      = r_out;
        n_out_vld  = r_out_vld;

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op      = owers_pkg::t_op'(i_in.operation);
                    n_sec     = w_in_sec;
                    n_cnt     = i_in.sector_count;
                    n_tag     = i_in.request_tag;
                    n_allow   = i_in.merge_allowed;
                    n_res     = '0;
                    n_mode    = owers_pkg::SM_SECTOR;
                    n_bounded = 1'b0;
                    n_skip_en = 1'b0;
                    n_key_sec = w_in_sec;
                    n_key_idx = r_next_idx;
                    n_state   = S_SCAN1;
                    n_start   = 1'b1;
                    case (owers_pkg::t_op'(i_in.operation))
                        owers_pkg::OP_ADD: begin
                            // collision check and successor of the new sector
                            n_bounded = 1'b1;
                        end
                        owers_pkg::OP_DISPATCH: begin
                            if (r_nvalid == '0) begin
                                n_res.status = owers_pkg::ST_EMPTY;
                                n_state      = S_DONE;
                                n_start      = 1'b0;
                            end else begin
                                n_mode = owers_pkg::SM_INDEX;
                            end
                        end
                        owers_pkg::OP_MERGE: begin
                            n_key_sec = w_end;
                        end
                        owers_pkg::OP_REMOVE: begin
                            n_mode = owers_pkg::SM_TAG;
                        end
                        default: begin
                            n_state = S_IDLE;
                            n_start = 1'b0;
                        end
                    endcase
                end
            end

            S_SCAN1: begin
                if (w_flags.done) begin
                    n_state = S_DONE;
                    case (r_op)
                        owers_pkg::OP_ADD: begin
                            if (w_flags.match_found) begin
                                // older request at the same sector goes out first
                                n_res                = f_report(owers_pkg::ST_DISPATCHED,
                                                                w_match_word);
                                n_valid[w_match_idx] = 1'b0;
                                n_valid[w_slot]      = 1'b1;
                                n_we                 = 1'b1;
                                n_waddr              = w_slot;
                                n_wdata              = {r_tag, r_cnt, r_sec};
                                n_next_vld           = w_flags.best_found;
                                n_next_idx           = w_flags.best_found ? w_best_idx : '0;
                            end else if (!w_flags.free_found) begin
                                n_res.status = owers_pkg::ST_FULL;
                            end else begin
                                n_valid[w_free_idx] = 1'b1;
                                n_nvalid            = r_nvalid + CW'(1);
                                n_we                = 1'b1;
                                n_waddr             = w_free_idx;
                                n_wdata             = {r_tag, r_cnt, r_sec};
                                n_res.status        = owers_pkg::ST_STORED;
                            end
                        end
                        owers_pkg::OP_DISPATCH: begin
                            // take the entry, then look for its successor
                            n_res              = f_report(owers_pkg::ST_DISPATCHED, w_sel_word);
                            n_valid[w_sel_idx] = 1'b0;
                            n_nvalid           = r_nvalid - CW'(1);
                            n_mode             = owers_pkg::SM_SECTOR;
                            n_bounded          = 1'b1;
                            n_skip_en          = 1'b1;
                            n_key_idx          = w_sel_idx;
                            n_key_sec          = w_sel_word[SB-1:0];
                            n_start            = 1'b1;
                            n_state            = S_SCAN2;
                        end
                        owers_pkg::OP_MERGE: begin
                            if (!w_flags.match_found || !r_allow || w_sum[NB]) begin
                                n_res.status = owers_pkg::ST_NO_MERGE;
                            end else begin
                                // grow the request downward, then check for a collision
                                n_we      = 1'b1;
                                n_waddr   = w_match_idx;
                                n_wdata   = w_merged;
                                n_res     = f_report(owers_pkg::ST_MERGED, w_merged);
                                n_mode    = owers_pkg::SM_SECTOR;
                                n_bounded = 1'b1;
                                n_skip_en = 1'b1;
                                n_key_idx = w_match_idx;
                                n_key_sec = r_sec;
                                n_start   = 1'b1;
                                n_state   = S_SCAN2;
                            end
                        end
                        owers_pkg::OP_REMOVE: begin
                            if (!w_flags.match_found) begin
                                n_res.status = owers_pkg::ST_NOT_FOUND;
                            end else begin
                                n_res                = f_report(owers_pkg::ST_STORED,
                                                                w_match_word);
                                n_valid[w_match_idx] = 1'b0;
                                n_nvalid             = r_nvalid - CW'(1);
                                if (r_next_vld && (r_next_idx == w_match_idx)) begin
                                    // pointer named the removed entry: move it on
                                    n_mode    = owers_pkg::SM_SECTOR;
                                    n_bounded = 1'b1;
                                    n_skip_en = 1'b1;
                                    n_key_idx = w_match_idx;
                                    n_key_sec = w_match_word[SB-1:0];
                                    n_start   = 1'b1;
                                    n_state   = S_SCAN2;
                                end
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN2: begin
                if (w_flags.done) begin
                    n_state = S_DONE;
                    case (r_op)
                        owers_pkg::OP_MERGE: begin
                            if (w_flags.match_found) begin
                                // other request at the new start goes out
                                n_res                = f_report(owers_pkg::ST_DISPATCHED,
                                                                w_match_word);
                                n_valid[w_match_idx] = 1'b0;
                                n_nvalid             = r_nvalid - CW'(1);
                                n_next_vld           = w_flags.best_found;
                                n_next_idx           = w_flags.best_found ? w_best_idx : '0;
                            end
                        end
                        owers_pkg::OP_DISPATCH, owers_pkg::OP_REMOVE: begin
                            n_next_vld = w_flags.best_found;
                            n_next_idx = w_flags.best_found ? w_best_idx : '0;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_DONE: begin
                // hand the result to the output register once it is free
                if (!r_out_vld || !i_out_stall) begin
                    n_out             = r_res;
                    n_out.queue_empty = (r_nvalid == '0);
                    n_out_vld         = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_start    <= 1'b0;
            r_valid    <= '0;
            r_nvalid   <= '0;
            r_next_idx <= '0;
            r_next_vld <= 1'b0;
            r_we       <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_start    <= n_start;
            r_valid    <= n_valid;
            r_nvalid   <= n_nvalid;
            r_next_idx <= n_next_idx;
            r_next_vld <= n_next_vld;
            r_we       <= n_we;
            r_out_vld  <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_sec     <= n_sec;
        r_cnt     <= n_cnt;
        r_tag     <= n_tag;
        r_allow   <= n_allow;
        r_mode    <= n_mode;
        r_bounded <= n_bounded;
        r_skip_en <= n_skip_en;
        r_key_sec <= n_key_sec;
        r_key_idx <= n_key_idx;
        r_waddr   <= n_waddr;
        r_wdata   <= n_wdata;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

### verif/tb_one_way_elevator_request_scheduler.sv
// ----------------------------------------------------------------------------
// tb_one_way_elevator_request_scheduler
// Self-checking testbench of the one-way (C-LOOK) request scheduler. A short
// stimulus table covers the extremes, every operation and the corner cases
// (collisions, an empty table, wrapping and blocked merges, duplicate
// tags). Random bursts that fill, drain or mix the table follow. Every item
// is run through a scoreboard model of the request table and each result is
// compared field by field in order.
// ----------------------------------------------------------------------------
module tb_one_way_elevator_request_scheduler;

    localparam int DEPTH      = owers_pkg::DEF_TABLE_DEPTH;
    localparam int SBITS      = owers_pkg::DEF_SECTOR_BITS;
    localparam int RAND_ITEMS = 1350;
    localparam int DRAIN_GAP  = 2 * DEPTH + 12;
    localparam int N_ROWS     = 26;

    // random burst flavors
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX   = 2;

    typedef logic [SBITS-1:0] t_sec;
    localparam t_sec MAX_SEC = '1;

    // one row of the stimulus table
    typedef struct {
        owers_pkg::t_in_item  item;
        bit                   has_want;
        owers_pkg::t_out_item want;
    } t_step_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    owers_pkg::t_in_item  i_in = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    owers_pkg::t_out_item o_out;
    logic                 i_out_stall = 1'b0;

    // scoreboard copy of the request table
    bit        tbl_vld [DEPTH];
    t_sec      tbl_sec [DEPTH];
    bit [15:0] tbl_cnt [DEPTH];
    bit [7:0]  tbl_tag [DEPTH];
    int        ptr_idx;
    bit        ptr_vld;

    owers_pkg::t_out_item pending_results[$];
    int                   fails = 0;
    bit                   calm = 1'b0;
    t_step_row            steps [N_ROWS];

    one_way_elevator_request_scheduler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // scoreboard model
    // ------------------------------------------------------------------

    // valid slot with the smallest sector above s, ignoring slot skip
    function automatic int next_above(t_sec s, int skip);
        int best;
        best = -1;
        for (int k = 0; k < DEPTH; k++) begin
            if (!tbl_vld[k] || k == skip || tbl_sec[k] <= s)
                continue;
            if (best < 0 || tbl_sec[k] < tbl_sec[best])
                best = k;
        end
        return best;
    endfunction

    function automatic int lowest_slot();
        int best;
        best = -1;
        for (int k = 0; k < DEPTH; k++) begin
            if (tbl_vld[k] && (best < 0 || tbl_sec[k] < tbl_sec[best]))
                best = k;
        end
        return best;
    endfunction

    function automatic int slot_at(t_sec s, int skip);
        for (int k = 0; k < DEPTH; k++)
            if (tbl_vld[k] && k != skip && tbl_sec[k] == s)
                return k;
        return -1;
    endfunction

    function automatic owers_pkg::t_out_item outcome(owers_pkg::t_status st, bit [7:0] tag,
                                                     t_sec sec, bit [15:0] cnt, bit qe);
        owers_pkg::t_out_item r;
        r.status      = st;
        r.out_tag     = tag;
        r.out_sector  = sec;
        r.out_count   = cnt;
        r.queue_empty = qe;
        return r;
    endfunction

    // result fields of slot k, or zeros when k is negative
    function automatic owers_pkg::t_out_item slot_report(owers_pkg::t_status st, int k);
        if (k < 0)
            return outcome(st, '0, '0, '0, 1'b0);
        return outcome(st, tbl_tag[k], tbl_sec[k], tbl_cnt[k], 1'b0);
    endfunction

    // hand out slot k and move the pointer to its successor
    function automatic owers_pkg::t_out_item serve_slot(int k, int skip);
        owers_pkg::t_out_item r;
        int s;
        s = next_above(tbl_sec[k], (skip >= 0) ? skip : k);
        if (s == k)
            s = -1;
        ptr_vld = (s >= 0);
        ptr_idx = (s >= 0) ? s : 0;
        r = slot_report(owers_pkg::ST_DISPATCHED, k);
        tbl_vld[k] = 1'b0;
        return r;
    endfunction

    function automatic owers_pkg::t_out_item sched_step(owers_pkg::t_in_item it);
        owers_pkg::t_out_item r;
        int                   k;
        int                   a;
        t_sec                 tail;
        r = '0;
        case (owers_pkg::t_op'(it.operation))
            owers_pkg::OP_ADD: begin
                a = slot_at(it.start_sector, -1);
                if (a >= 0)
                    r = serve_slot(a, -1);
                k = -1;
                for (int j = 0; j < DEPTH && k < 0; j++)
                    if (!tbl_vld[j])
                        k = j;
                if (k < 0) begin
                    r = slot_report(owers_pkg::ST_FULL, -1);
                end else begin
                    tbl_vld[k] = 1'b1;
                    tbl_sec[k] = it.start_sector;
                    tbl_cnt[k] = it.sector_count;
                    tbl_tag[k] = it.request_tag;
                    if (a < 0)
                        r = slot_report(owers_pkg::ST_STORED, -1);
                end
            end
            owers_pkg::OP_DISPATCH: begin
                if (lowest_slot() < 0) begin
                    r = slot_report(owers_pkg::ST_EMPTY, -1);
                end else begin
                    k = (ptr_vld && tbl_vld[ptr_idx]) ? ptr_idx : lowest_slot();
                    r = serve_slot(k, -1);
                end
            end
            owers_pkg::OP_MERGE: begin
                tail = it.start_sector + t_sec'(it.sector_count);
                k = slot_at(tail, -1);
                if (k < 0 || !it.merge_allowed ||
                    ({1'b0, tbl_cnt[k]} + {1'b0, it.sector_count}) > 17'hFFFF) begin
                    r = slot_report(owers_pkg::ST_NO_MERGE, -1);
                end else begin
                    tbl_sec[k] = it.start_sector;
                    tbl_cnt[k] = tbl_cnt[k] + it.sector_count;
                    a = slot_at(it.start_sector, k);
                    r = (a >= 0) ? serve_slot(a, k) : slot_report(owers_pkg::ST_MERGED, k);
                end
            end
            default: begin
                k = -1;
                for (int j = 0; j < DEPTH && k < 0; j++)
                    if (tbl_vld[j] && tbl_tag[j] == it.request_tag)
                        k = j;
                if (k < 0) begin
                    r = slot_report(owers_pkg::ST_NOT_FOUND, -1);
                end else begin
                    // pointer to the removed slot moves on to its successor
                    if (ptr_vld && ptr_idx == k) begin
                        a = next_above(tbl_sec[k], k);
                        ptr_vld = (a >= 0);
                        ptr_idx = (a >= 0) ? a : 0;
                    end
                    r = slot_report(owers_pkg::ST_STORED, k);
                    tbl_vld[k] = 1'b0;
                end
            end
        endcase
        r.queue_empty = (lowest_slot() < 0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic owers_pkg::t_in_item cmd(owers_pkg::t_op op, t_sec sec,
                                                bit [15:0] cnt, bit [7:0] tag, bit allow);
        owers_pkg::t_in_item it;
        it.operation     = op;
        it.start_sector  = sec;
        it.sector_count  = cnt;
        it.request_tag   = tag;
        it.merge_allowed = allow;
        return it;
    endfunction

    // a random valid slot, or -1 on an empty table
    function automatic int any_valid_slot();
        int base;
        base = $urandom_range(DEPTH - 1);
        for (int j = 0; j < DEPTH; j++)
            if (tbl_vld[(base + j) % DEPTH])
                return (base + j) % DEPTH;
        return -1;
    endfunction

    function automatic owers_pkg::t_in_item rand_item(int mode);
        owers_pkg::t_in_item it;
        int                  roll;
        int                  k;
        roll = $urandom_range(99);
        it.merge_allowed = 1'($urandom_range(1));
        it.request_tag   = ($urandom_range(99) < 60) ? 8'($urandom_range(15))
                                                     : 8'($urandom_range(255));
        it.sector_count  = ($urandom_range(3) != 0) ? 16'($urandom_range(32, 1))
                                                    : 16'($urandom_range(65535, 1));
        // small sectors collide often, the top and full range cover the wide bits
        case ($urandom_range(3))
            0, 1: it.start_sector = t_sec'($urandom_range(40));
            2:    it.start_sector = MAX_SEC - t_sec'($urandom_range(40));
            default: it.start_sector = {16'($urandom()), 32'($urandom())};
        endcase
        case (mode)
            MODE_FILL:  it.operation = (roll < 70) ? owers_pkg::OP_ADD :
                                       (roll < 80) ? owers_pkg::OP_DISPATCH :
                                       (roll < 90) ? owers_pkg::OP_MERGE :
                                                     owers_pkg::OP_REMOVE;
            MODE_DRAIN: it.operation = (roll < 15) ? owers_pkg::OP_ADD :
                                       (roll < 75) ? owers_pkg::OP_DISPATCH :
                                       (roll < 85) ? owers_pkg::OP_MERGE :
                                                     owers_pkg::OP_REMOVE;
            default:    it.operation = owers_pkg::t_op'(roll % 4);
        endcase
        // aim removes and merges at live requests most of the time
        if (it.operation == owers_pkg::OP_REMOVE && $urandom_range(99) < 70) begin
            k = any_valid_slot();
            if (k >= 0)
                it.request_tag = tbl_tag[k];
        end
        if (it.operation == owers_pkg::OP_MERGE && $urandom_range(99) < 65) begin
            k = any_valid_slot();
            if (k >= 0) begin
                it.start_sector  = tbl_sec[k] - t_sec'(it.sector_count);
                it.merge_allowed = ($urandom_range(99) < 85);
            end
        end
        return it;
    endfunction

    // hand one item to the block and log what it should answer
    task automatic send_item(input owers_pkg::t_in_item it, input bit use_typed,
                             input owers_pkg::t_out_item typed);
        owers_pkg::t_out_item r;
        while (!calm && $urandom_range(99) < 8) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (o_in_stall);
        r = sched_step(it);
        pending_results.push_back(use_typed ? typed : r);
    endtask

    // hold off new items until all results are back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // receiver stall
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 8);
    end

    // ------------------------------------------------------------------
    // result check
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        owers_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result st=%0d tag=%0d sec=%0h cnt=%0d qe=%0b",
                             o_out.status, o_out.out_tag, o_out.out_sector,
                             o_out.out_count, o_out.queue_empty);
            end else begin
                want = pending_results.pop_front();
                if (o_out.status !== want.status || o_out.out_tag !== want.out_tag ||
                    o_out.out_sector !== want.out_sector ||
                    o_out.out_count !== want.out_count ||
                    o_out.queue_empty !== want.queue_empty) begin
                    fails++;
                    if (fails <= 10)
                        $display({"mismatch: want st=%0d tag=%0d sec=%0h cnt=%0d qe=%0b,",
                                  " got st=%0d tag=%0d sec=%0h cnt=%0d qe=%0b"},
                                 want.status, want.out_tag, want.out_sector,
                                 want.out_count, want.queue_empty,
                                 o_out.status, o_out.out_tag, o_out.out_sector,
                                 o_out.out_count, o_out.queue_empty);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int n;
        int mode;
        int burst;

        for (int k = 0; k < DEPTH; k++)
            tbl_vld[k] = 1'b0;
        ptr_idx = 0;
        ptr_vld = 1'b0;

        // empty table, then extremes, collisions, merges and duplicate tags
        steps[0]  = '{cmd(owers_pkg::OP_DISPATCH, 0, 1, 0, 1), 1'b1,
                      outcome(owers_pkg::ST_EMPTY, 0, 0, 0, 1'b1)};
        steps[1]  = '{cmd(owers_pkg::OP_REMOVE, 0, 1, 8'hA5, 0), 1'b1,
                      outcome(owers_pkg::ST_NOT_FOUND, 0, 0, 0, 1'b1)};
        steps[2]  = '{cmd(owers_pkg::OP_MERGE, 10, 5, 0, 1), 1'b1,
                      outcome(owers_pkg::ST_NO_MERGE, 0, 0, 0, 1'b1)};
        steps[3]  = '{cmd(owers_pkg::OP_ADD, 100, 8, 1, 0), 1'b1,
                      outcome(owers_pkg::ST_STORED, 0, 0, 0, 1'b0)};
        steps[4]  = '{cmd(owers_pkg::OP_ADD, MAX_SEC, 16'hFFFF, 8'hFF, 1), 1'b1,
                      outcome(owers_pkg::ST_STORED, 0, 0, 0, 1'b0)};
        steps[5]  = '{cmd(owers_pkg::OP_ADD, 0, 1, 0, 0), 1'b1,
                      outcome(owers_pkg::ST_STORED, 0, 0, 0, 1'b0)};
        steps[6]  = '{cmd(owers_pkg::OP_ADD, 100, 4, 2, 1), 1'b1,
                      outcome(owers_pkg::ST_DISPATCHED, 1, 100, 8, 1'b0)};
        steps[7]  = '{cmd(owers_pkg::OP_MERGE, 90, 10, 0, 1), 1'b0, '0};
        steps[8]  = '{cmd(owers_pkg::OP_MERGE, 80, 10, 0, 0), 1'b1,
                      outcome(owers_pkg::ST_NO_MERGE, 0, 0, 0, 1'b0)};
        steps[9]  = '{cmd(owers_pkg::OP_MERGE, MAX_SEC - 1, 1, 0, 1), 1'b1,
                      outcome(owers_pkg::ST_NO_MERGE, 0, 0, 0, 1'b0)};
        // end sector wraps to zero and the grown request lands on the top one
        steps[10] = '{cmd(owers_pkg::OP_MERGE, MAX_SEC, 1, 0, 1), 1'b1,
                      outcome(owers_pkg::ST_DISPATCHED, 8'hFF, MAX_SEC, 16'hFFFF, 1'b0)};
        steps[11] = '{cmd(owers_pkg::OP_ADD, 200, 3, 7, 0), 1'b0, '0};
        steps[12] = '{cmd(owers_pkg::OP_ADD, 300, 3, 7, 0), 1'b0, '0};
        steps[13] = '{cmd(owers_pkg::OP_DISPATCH, 0, 1, 0, 0), 1'b0, '0};
        steps[14] = '{cmd(owers_pkg::OP_MERGE, 190, 10, 0, 1), 1'b0, '0};
        steps[15] = '{cmd(owers_pkg::OP_DISPATCH, 0, 1, 0, 0), 1'b0, '0};
        steps[16] = '{cmd(owers_pkg::OP_ADD, 400, 2, 7, 1), 1'b0, '0};
        steps[17] = '{cmd(owers_pkg::OP_ADD, 350, 2, 7, 1), 1'b0, '0};
        steps[18] = '{cmd(owers_pkg::OP_REMOVE, 0, 1, 7, 0), 1'b0, '0};
        steps[19] = '{cmd(owers_pkg::OP_ADD, 48'hAAAA_5555_AAAA, 16'h5A5A, 8'h5A, 1),
                      1'b0, '0};
        steps[20] = '{cmd(owers_pkg::OP_ADD, 48'h5555_AAAA_5555, 16'hA5A5, 8'hA5, 0),
                      1'b0, '0};
        steps[21] = '{cmd(owers_pkg::OP_DISPATCH, 0, 1, 0, 0), 1'b0, '0};
        steps[22] = '{cmd(owers_pkg::OP_DISPATCH, 0, 1, 0, 0), 1'b0, '0};
        steps[23] = '{cmd(owers_pkg::OP_DISPATCH, 0, 1, 0, 0), 1'b0, '0};
        steps[24] = '{cmd(owers_pkg::OP_DISPATCH, 0, 1, 0, 0), 1'b0, '0};
        steps[25] = '{cmd(owers_pkg::OP_DISPATCH, 0, 1, 0, 0), 1'b0, '0};

        // reset
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steps[k])
            send_item(steps[k].item, steps[k].has_want, steps[k].want);
        drain_results();

        // random bursts; one stretch runs with no idling on either side
        n = 0;
        while (n < RAND_ITEMS) begin
            mode  = $urandom_range(MODE_MIX);
            burst = $urandom_range(60, 20);
            for (int k = 0; k < burst && n < RAND_ITEMS; k++) begin
                calm = (n >= 500 && n < 800);
                send_item(rand_item(mode), 1'b0, '0);
                n++;
                if (n % 300 == 0)
                    drain_results();
            end
        end
        calm = 1'b0;

        // wait for the last results, then watch for strays
        drain_results();
        repeat (DRAIN_GAP) @(posedge i_clk);

        if (fails == 0)
            $display("[one_way_elevator_request_scheduler] OK");
        else
            $display("[one_way_elevator_request_scheduler] ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #20000000;
        $display("[one_way_elevator_request_scheduler] ERROR");
        $finish;
    end

endmodule
